>>> sv/c8eu_pkg.sv
// package: opcode classes, decode table, queue item and stack constants
`default_nettype none
package c8eu_pkg;

   localparam int STACK_DEPTH = 256;
   localparam int STK_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam logic [15:0] START_RESET = 16'h0200;
   localparam logic [7:0] SP_RESET = 8'hFF;
   localparam logic [1:0] REG_START_ADDR = 2'd0;

   typedef enum logic [5:0] {
      K_ILL, K_LDA, K_STA, K_ADC, K_SBC, K_AND, K_ORA, K_EOR, K_CMP, K_BIT,
      K_LDX, K_LDY, K_STX, K_STY, K_INX, K_INY, K_DEX, K_DEY, K_CPX, K_CPY,
      K_TAX, K_TXA, K_TAY, K_TYA, K_JSR, K_RTS, K_PHA, K_PLA, K_TXS, K_TSX,
      K_PHP, K_PLP, K_LSRA, K_LSRM, K_ASLA, K_ASLM, K_SEC, K_CLC, K_SEI,
      K_CLI, K_SED, K_CLD, K_CLV, K_BR
   } kind_type;

   typedef enum logic [1:0] {ST_EXEC, ST_PULL1, ST_PULL2, ST_PUSH2} back_state_type;

   typedef struct packed {
      kind_type kind;
      logic [1:0] len;
   } dec_type;

   typedef struct packed {
      kind_type kind;
      logic [1:0] len;
      logic [7:0] opcode;
      logic [7:0] operand;
      logic [15:0] target;
   } item_type;

   typedef struct packed {
      logic load;
      logic [15:0] value;
   } pc_load_type;

   function automatic dec_type decode(input logic [7:0] op);
      dec_type d;
      d.len = 2'd2;
      d.kind = K_ILL;
      unique case (op)
         8'hAD, 8'hBD, 8'hB9: begin d.kind = K_LDA; d.len = 2'd3; end
         8'hA9, 8'hA5, 8'hB5, 8'hA1, 8'hB1: d.kind = K_LDA;
         8'h8D, 8'h9D, 8'h99: begin d.kind = K_STA; d.len = 2'd3; end
         8'h85, 8'h95, 8'h81, 8'h91: d.kind = K_STA;
         8'h6D, 8'h7D, 8'h79: begin d.kind = K_ADC; d.len = 2'd3; end
         8'h69, 8'h65, 8'h75, 8'h61, 8'h71: d.kind = K_ADC;
         8'hED, 8'hFD, 8'hF9: begin d.kind = K_SBC; d.len = 2'd3; end
         8'hE9, 8'hE5, 8'hF5, 8'hE1, 8'hF1: d.kind = K_SBC;
         8'h2D, 8'h3D, 8'h39: begin d.kind = K_AND; d.len = 2'd3; end
         8'h29, 8'h25, 8'h35, 8'h21, 8'h31: d.kind = K_AND;
         8'h0D, 8'h1D, 8'h19: begin d.kind = K_ORA; d.len = 2'd3; end
         8'h09, 8'h05, 8'h15, 8'h01, 8'h11: d.kind = K_ORA;
         8'h4D, 8'h5D, 8'h59: begin d.kind = K_EOR; d.len = 2'd3; end
         8'h49, 8'h45, 8'h55, 8'h41, 8'h51: d.kind = K_EOR;
         8'hCD, 8'hDD, 8'hD9: begin d.kind = K_CMP; d.len = 2'd3; end
         8'hC9, 8'hC5, 8'hD5, 8'hC1, 8'hD1: d.kind = K_CMP;
         8'h2C: begin d.kind = K_BIT; d.len = 2'd3; end
         8'h24: d.kind = K_BIT;
         8'hAE, 8'hBE: begin d.kind = K_LDX; d.len = 2'd3; end
         8'hA2, 8'hA6, 8'hB6: d.kind = K_LDX;
         8'hAC, 8'hBC: begin d.kind = K_LDY; d.len = 2'd3; end
         8'hA0, 8'hA4, 8'hB4: d.kind = K_LDY;
         8'h8E: begin d.kind = K_STX; d.len = 2'd3; end
         8'h86, 8'h96: d.kind = K_STX;
         8'h8C: begin d.kind = K_STY; d.len = 2'd3; end
         8'h84, 8'h94: d.kind = K_STY;
         8'hEC: begin d.kind = K_CPX; d.len = 2'd3; end
         8'hE0, 8'hE4: d.kind = K_CPX;
         8'hCC: begin d.kind = K_CPY; d.len = 2'd3; end
         8'hC0, 8'hC4: d.kind = K_CPY;
         8'h4E, 8'h5E: begin d.kind = K_LSRM; d.len = 2'd3; end
         8'h46, 8'h56: d.kind = K_LSRM;
         8'h0E, 8'h1E: begin d.kind = K_ASLM; d.len = 2'd3; end
         8'h06, 8'h16: d.kind = K_ASLM;
         8'h20: begin d.kind = K_JSR; d.len = 2'd3; end
         8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hB0, 8'hD0, 8'hF0: d.kind = K_BR;
         8'hE8: begin d.kind = K_INX; d.len = 2'd1; end
         8'hC8: begin d.kind = K_INY; d.len = 2'd1; end
         8'hCA: begin d.kind = K_DEX; d.len = 2'd1; end
         8'h88: begin d.kind = K_DEY; d.len = 2'd1; end
         8'hAA: begin d.kind = K_TAX; d.len = 2'd1; end
         8'h8A: begin d.kind = K_TXA; d.len = 2'd1; end
         8'hA8: begin d.kind = K_TAY; d.len = 2'd1; end
         8'h98: begin d.kind = K_TYA; d.len = 2'd1; end
         8'h60: begin d.kind = K_RTS; d.len = 2'd1; end
         8'h48: begin d.kind = K_PHA; d.len = 2'd1; end
         8'h68: begin d.kind = K_PLA; d.len = 2'd1; end
         8'h9A: begin d.kind = K_TXS; d.len = 2'd1; end
         8'hBA: begin d.kind = K_TSX; d.len = 2'd1; end
         8'h08: begin d.kind = K_PHP; d.len = 2'd1; end
         8'h28: begin d.kind = K_PLP; d.len = 2'd1; end
         8'h4A: begin d.kind = K_LSRA; d.len = 2'd1; end
         8'h0A: begin d.kind = K_ASLA; d.len = 2'd1; end
         8'h38: begin d.kind = K_SEC; d.len = 2'd1; end
         8'h18: begin d.kind = K_CLC; d.len = 2'd1; end
         8'h78: begin d.kind = K_SEI; d.len = 2'd1; end
         8'h58: begin d.kind = K_CLI; d.len = 2'd1; end
         8'hF8: begin d.kind = K_SED; d.len = 2'd1; end
         8'hD8: begin d.kind = K_CLD; d.len = 2'd1; end
         8'hB8: begin d.kind = K_CLV; d.len = 2'd1; end
         default: begin d.kind = K_ILL; d.len = 2'd1; end
      endcase
      return d;
   endfunction

endpackage
`default_nettype wire

>>> sv/c8eu_front.sv
// front end: accepts instructions, decodes them and queues them for execution
`default_nettype none
module c8eu_front (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [7:0] req_opcode,
   input  wire logic [7:0] req_operand_value,
   input  wire logic [15:0] req_jump_target,
   output logic head_valid,
   output c8eu_pkg::item_type head_item,
   input  wire logic head_pop
);
   import c8eu_pkg::*;

   item_type q_ff [2];
   logic wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic push;
   dec_type dec;
   item_type new_item;

   assign req_ready = (count_ff != 2'd2);
   assign push = req_valid && req_ready;
   assign head_valid = (count_ff != 2'd0);
   assign head_item = q_ff[rd_ptr_ff];

   always_comb begin
      dec = decode(req_opcode);
      new_item.kind = dec.kind;
      new_item.len = dec.len;
      new_item.opcode = req_opcode;
      new_item.operand = req_operand_value;
      new_item.target = req_jump_target;
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = head_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, head_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= new_item;
   end

endmodule
`default_nettype wire

>>> sv/c8eu_back.sv
// back end: register file, stack page, instruction execution and result register
`default_nettype none
module c8eu_back (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic head_valid,
   input  wire c8eu_pkg::item_type head_item,
   output logic head_pop,
   input  wire c8eu_pkg::pc_load_type pc_load,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic rsp_write_enable,
   output logic [7:0] rsp_write_data,
   output logic [7:0] rsp_acc_out,
   output logic [7:0] rsp_x_out,
   output logic [7:0] rsp_y_out,
   output logic [7:0] rsp_sp_out,
   output logic [7:0] rsp_status_out,
   output logic [15:0] rsp_pc_out,
   output logic rsp_illegal
);
   import c8eu_pkg::*;

   back_state_type state_ff, state_in;
   logic [7:0] a_ff, a_in, x_ff, x_in, y_ff, y_in, sp_ff, sp_in, p_ff, p_in;
   logic [15:0] pc_ff, pc_in;
   logic [7:0] lo_ff, lo_in;

   logic [7:0] mem [STACK_DEPTH];
   logic [7:0] rd_raw_ff;
   logic [7:0] pdat;
   logic wr_en, rd_en;
   logic [STK_AW-1:0] wr_addr, rd_addr;
   logic [7:0] wr_byte;

   logic clr_busy_ff, clr_busy_in;
   logic [STK_AW-1:0] clr_addr_ff, clr_addr_in;
   logic exec_ok;

   logic out_free, finish;
   logic o_valid_ff, o_we_ff, o_we_in, o_ill_ff, o_ill_in;
   logic [7:0] o_wd_ff, o_wd_in;

   logic [7:0] m, cmp_r, nz_v, res8;
   logic [8:0] sum9, diff9;
   logic [15:0] next_pc, ret_pc;
   logic taken, flag_bit, set_nz_en;

   assign out_free = !o_valid_ff || rsp_ready;
   assign pdat = rd_raw_ff;
   assign m = head_item.operand;
   assign exec_ok = head_valid && !clr_busy_ff;

   // state sequencing
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_EXEC: begin
            if (exec_ok && out_free) begin
               if (head_item.kind == K_PLA || head_item.kind == K_PLP ||
                   head_item.kind == K_RTS) begin
                  state_in = ST_PULL1;
               end else if (head_item.kind == K_JSR) begin
                  state_in = ST_PUSH2;
               end
            end
         end
         ST_PULL1: begin
            if (head_item.kind == K_RTS) state_in = ST_PULL2;
            else if (out_free) state_in = ST_EXEC;
         end
         ST_PULL2: if (out_free) state_in = ST_EXEC;
         ST_PUSH2: if (out_free) state_in = ST_EXEC;
         default: state_in = ST_EXEC;
      endcase
   end

   // execute
   always_comb begin
      a_in = a_ff; x_in = x_ff; y_in = y_ff; sp_in = sp_ff; p_in = p_ff;
      pc_in = pc_ff; lo_in = lo_ff;
      o_we_in = 1'b0; o_wd_in = 8'h00; o_ill_in = 1'b0;
      wr_en = 1'b0; wr_addr = sp_ff[STK_AW-1:0]; wr_byte = 8'h00;
      rd_en = 1'b0; rd_addr = sp_in[STK_AW-1:0];
      finish = 1'b0; set_nz_en = 1'b0; nz_v = 8'h00; cmp_r = a_ff;
      next_pc = pc_ff + {14'd0, head_item.len};
      ret_pc = pc_ff + 16'd2;
      sum9 = {1'b0, a_ff} + {1'b0, (head_item.kind == K_SBC) ? ~m : m} + {8'd0, p_ff[0]};
      if (head_item.kind == K_CPX) cmp_r = x_ff;
      else if (head_item.kind == K_CPY) cmp_r = y_ff;
      diff9 = {1'b0, cmp_r} - {1'b0, m};
      unique case (head_item.opcode[7:6])
         2'd0: flag_bit = p_ff[7];
         2'd1: flag_bit = p_ff[6];
         2'd2: flag_bit = p_ff[0];
         default: flag_bit = p_ff[1];
      endcase
      taken = (flag_bit == head_item.opcode[5]);
      res8 = 8'h00;

      unique case (state_ff)
         ST_EXEC: begin
            if (exec_ok) begin
               unique case (head_item.kind)
                  K_PLA, K_PLP, K_RTS: begin
                     if (out_free) begin
                        sp_in = sp_ff + 8'd1;
                        rd_en = 1'b1;
                        rd_addr = sp_in[STK_AW-1:0];
                     end
                  end
                  K_JSR: begin
                     if (out_free) begin
                        wr_en = 1'b1;
                        wr_byte = ret_pc[15:8];
                        sp_in = sp_ff - 8'd1;
                     end
                  end
                  default: begin
                     if (out_free) begin
                        finish = 1'b1;
                        pc_in = next_pc;
                        unique case (head_item.kind)
                           K_LDA: begin a_in = m; set_nz_en = 1'b1; nz_v = m; end
                           K_STA: begin o_we_in = 1'b1; o_wd_in = a_ff; end
                           K_ADC, K_SBC: begin
                              a_in = sum9[7:0];
                              p_in[0] = sum9[8];
                              p_in[6] = (a_ff[7] ^ sum9[7]) &
                                 (((head_item.kind == K_SBC) ? ~m[7] : m[7]) ^ sum9[7]);
                              set_nz_en = 1'b1; nz_v = sum9[7:0];
                           end
                           K_AND: begin
                              res8 = a_ff & m; a_in = res8;
                              set_nz_en = 1'b1; nz_v = res8;
                           end
                           K_ORA: begin
                              res8 = a_ff | m; a_in = res8;
                              set_nz_en = 1'b1; nz_v = res8;
                           end
                           K_EOR: begin
                              res8 = a_ff ^ m; a_in = res8;
                              set_nz_en = 1'b1; nz_v = res8;
                           end
                           K_CMP, K_CPX, K_CPY: begin
                              p_in[0] = !diff9[8];
                              set_nz_en = 1'b1; nz_v = diff9[7:0];
                           end
                           K_BIT: begin
                              p_in[1] = ((a_ff & m) == 8'h00);
                              p_in[7] = m[7];
                              p_in[6] = m[6];
                           end
                           K_LDX: begin x_in = m; set_nz_en = 1'b1; nz_v = m; end
                           K_LDY: begin y_in = m; set_nz_en = 1'b1; nz_v = m; end
                           K_STX: begin o_we_in = 1'b1; o_wd_in = x_ff; end
                           K_STY: begin o_we_in = 1'b1; o_wd_in = y_ff; end
                           K_INX: begin
                              x_in = x_ff + 8'd1; set_nz_en = 1'b1; nz_v = x_in;
                           end
                           K_INY: begin
                              y_in = y_ff + 8'd1; set_nz_en = 1'b1; nz_v = y_in;
                           end
                           K_DEX: begin
                              x_in = x_ff - 8'd1; set_nz_en = 1'b1; nz_v = x_in;
                           end
                           K_DEY: begin
                              y_in = y_ff - 8'd1; set_nz_en = 1'b1; nz_v = y_in;
                           end
                           K_TAX: begin x_in = a_ff; set_nz_en = 1'b1; nz_v = a_ff; end
                           K_TXA: begin a_in = x_ff; set_nz_en = 1'b1; nz_v = x_ff; end
                           K_TAY: begin y_in = a_ff; set_nz_en = 1'b1; nz_v = a_ff; end
                           K_TYA: begin a_in = y_ff; set_nz_en = 1'b1; nz_v = y_ff; end
                           K_PHA: begin
                              wr_en = 1'b1; wr_byte = a_ff; sp_in = sp_ff - 8'd1;
                           end
                           K_PHP: begin
                              wr_en = 1'b1; wr_byte = p_ff | 8'h30;
                              sp_in = sp_ff - 8'd1;
                           end
                           K_TXS: sp_in = x_ff;
                           K_TSX: begin x_in = sp_ff; set_nz_en = 1'b1; nz_v = sp_ff; end
                           K_LSRA: begin
                              p_in[0] = a_ff[0]; res8 = {1'b0, a_ff[7:1]};
                              a_in = res8; set_nz_en = 1'b1; nz_v = res8;
                           end
                           K_ASLA: begin
                              p_in[0] = a_ff[7]; res8 = {a_ff[6:0], 1'b0};
                              a_in = res8; set_nz_en = 1'b1; nz_v = res8;
                           end
                           K_LSRM: begin
                              p_in[0] = m[0]; res8 = {1'b0, m[7:1]};
                              o_we_in = 1'b1; o_wd_in = res8;
                              set_nz_en = 1'b1; nz_v = res8;
                           end
                           K_ASLM: begin
                              p_in[0] = m[7]; res8 = {m[6:0], 1'b0};
                              o_we_in = 1'b1; o_wd_in = res8;
                              set_nz_en = 1'b1; nz_v = res8;
                           end
                           K_SEC: p_in[0] = 1'b1;
                           K_CLC: p_in[0] = 1'b0;
                           K_SEI: p_in[2] = 1'b1;
                           K_CLI: p_in[2] = 1'b0;
                           K_SED: p_in[3] = 1'b1;
                           K_CLD: p_in[3] = 1'b0;
                           K_CLV: p_in[6] = 1'b0;
                           K_BR: if (taken) pc_in = next_pc + {{8{m[7]}}, m};
                           default: o_ill_in = 1'b1;
                        endcase
                     end
                  end
               endcase
            end
         end
         ST_PULL1: begin
            if (head_item.kind == K_RTS) begin
               lo_in = pdat;
               sp_in = sp_ff + 8'd1;
               rd_en = 1'b1;
               rd_addr = sp_in[STK_AW-1:0];
            end else if (out_free) begin
               finish = 1'b1;
               pc_in = next_pc;
               if (head_item.kind == K_PLA) begin
                  a_in = pdat; set_nz_en = 1'b1; nz_v = pdat;
               end else begin
                  p_in = pdat & 8'hCF;
               end
            end
         end
         ST_PULL2: begin
            if (out_free) begin
               finish = 1'b1;
               pc_in = {pdat, lo_ff} + 16'd1;
            end
         end
         ST_PUSH2: begin
            if (out_free) begin
               finish = 1'b1;
               wr_en = 1'b1;
               wr_byte = ret_pc[7:0];
               sp_in = sp_ff - 8'd1;
               pc_in = head_item.target;
            end
         end
         default: ;
      endcase

      if (set_nz_en) begin
         p_in[7] = nz_v[7];
         p_in[1] = (nz_v == 8'h00);
      end
      if (pc_load.load) pc_in = pc_load.value;
   end

   assign head_pop = finish;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_EXEC;
         a_ff <= 8'h00; x_ff <= 8'h00; y_ff <= 8'h00;
         sp_ff <= SP_RESET; p_ff <= 8'h00; pc_ff <= START_RESET;
         o_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         a_ff <= a_in; x_ff <= x_in; y_ff <= y_in;
         sp_ff <= sp_in; p_ff <= p_in; pc_ff <= pc_in;
         if (finish) o_valid_ff <= 1'b1;
         else if (rsp_ready) o_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      if (finish) begin
         o_we_ff <= o_we_in;
         o_wd_ff <= o_wd_in;
         o_ill_ff <= o_ill_in;
      end
   end

   // clearing pass over the stack page after reset
   always_comb begin
      clr_addr_in = clr_addr_ff + {{(STK_AW-1){1'b0}}, 1'b1};
      clr_busy_in = clr_busy_ff && (clr_addr_ff != {STK_AW{1'b1}});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= {STK_AW{1'b0}};
      end else if (clr_busy_ff) begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // stack page
   always_ff @(posedge clock) begin
      if (clr_busy_ff) mem[clr_addr_ff] <= 8'h00;
      else if (wr_en) mem[wr_addr] <= wr_byte;
      if (rd_en) rd_raw_ff <= mem[rd_addr];
   end

   assign rsp_valid = o_valid_ff;
   assign rsp_write_enable = o_we_ff;
   assign rsp_write_data = o_wd_ff;
   assign rsp_acc_out = a_ff;
   assign rsp_x_out = x_ff;
   assign rsp_y_out = y_ff;
   assign rsp_sp_out = sp_ff;
   assign rsp_status_out = p_ff;
   assign rsp_pc_out = pc_ff;
   assign rsp_illegal = o_ill_ff;

endmodule
`default_nettype wire

>>> sv/cpu_8bit_execute_unit_top.sv
// top level: 8-bit cpu execute unit with decode queue, execute stage and register port
//
//  channel  | handshake              | payload
//  req      | req_valid / req_ready  | opcode, operand_value, jump_target
//  rsp      | rsp_valid / rsp_ready  | write_enable .. illegal (state after instruction)
//  csr      | psel/penable/pwrite    | paddr, pwdata, prdata, pready tied high
//
// one instruction per cycle while rsp_ready is high; JSR adds ST_PUSH2, PLA/PLP
// add ST_PULL1, RTS both pull states; set by the single-port stack page, registered read
// rsp_valid rises the cycle after an instruction's last execute cycle
// synchronous reset clears a, x, y, status, sp = FF, pc = start_address, then a pass
// over every stack page address zeroes it before execution starts
// a two-entry decode queue lets input and output stall independently
`default_nettype none
module cpu_8bit_execute_unit_top (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [7:0] req_opcode,
   input  wire logic [7:0] req_operand_value,
   input  wire logic [15:0] req_jump_target,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic rsp_write_enable,
   output logic [7:0] rsp_write_data,
   output logic [7:0] rsp_acc_out,
   output logic [7:0] rsp_x_out,
   output logic [7:0] rsp_y_out,
   output logic [7:0] rsp_sp_out,
   output logic [7:0] rsp_status_out,
   output logic [15:0] rsp_pc_out,
   output logic rsp_illegal,
   input  wire logic psel,
   input  wire logic penable,
   input  wire logic pwrite,
   input  wire logic [1:0] paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);
   import c8eu_pkg::*;

   logic [15:0] start_ff;
   logic head_valid, head_pop;
   item_type head_item;
   pc_load_type pc_load;

   assign pready = 1'b1;
   assign pc_load.load = psel && penable && pwrite && (paddr == REG_START_ADDR);
   assign pc_load.value = pwdata[15:0];
   assign prdata = (paddr == REG_START_ADDR) ? {16'h0000, start_ff} : 32'h0;

   always_ff @(posedge clock) begin
      if (reset) start_ff <= START_RESET;
      else if (pc_load.load) start_ff <= pc_load.value;
   end

   c8eu_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_opcode, .req_operand_value,
      .req_jump_target, .head_valid, .head_item, .head_pop
   );

   c8eu_back u_back (
      .clock, .reset, .head_valid, .head_item, .head_pop, .pc_load,
      .rsp_valid, .rsp_ready, .rsp_write_enable, .rsp_write_data, .rsp_acc_out,
      .rsp_x_out, .rsp_y_out, .rsp_sp_out, .rsp_status_out, .rsp_pc_out, .rsp_illegal
   );

endmodule
`default_nettype wire

>>> sv/c8eu_checker.sv
// port checker for the execute unit, bound to the top level
`default_nettype none
module c8eu_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_write_enable,
   input wire logic [7:0] rsp_write_data,
   input wire logic [7:0] rsp_status_out,
   input wire logic rsp_illegal
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_ill_nowrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_illegal |-> !rsp_write_enable)
      else $error("illegal opcode wrote memory");

   a_wd_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_enable |-> rsp_write_data == 8'h00)
      else $error("write data without write");

   a_status_unused: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status_out[5:4] == 2'b00)
      else $error("unused status bits set");

endmodule

bind cpu_8bit_execute_unit_top c8eu_checker u_c8eu_checker (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_write_enable, .rsp_write_data,
   .rsp_status_out, .rsp_illegal
);
`default_nettype wire
